### src/imu_oc_pkg.sv
`timescale 1ns / 1ps
package imu_oc_pkg;

	localparam int NUM_AXES = 6;
	localparam int AXIS_IDX_W = $clog2(NUM_AXES);
	localparam int SUM_W = 32;
	localparam int DATA_W = 16;
	localparam int DIV_CNT_W = $clog2(SUM_W);

	localparam logic [DATA_W-1:0] CALIB_COUNT_RST = 16'd100;
	localparam logic signed [DATA_W-1:0] ONE_G_POS = 16'sd16384;
	localparam logic signed [DATA_W-1:0] ONE_G_NEG = -16'sd16384;

	localparam logic CMD_MEASURE = 1'b0;
	localparam logic CMD_CALIBRATE = 1'b1;

	typedef struct packed {
		logic cmd;
		logic signed [15:0] raw_accel_x;
		logic signed [15:0] raw_accel_y;
		logic signed [15:0] raw_accel_z;
		logic signed [15:0] raw_temperature;
		logic signed [15:0] raw_gyro_x;
		logic signed [15:0] raw_gyro_y;
		logic signed [15:0] raw_gyro_z;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] corr_accel_x;
		logic signed [15:0] corr_accel_y;
		logic signed [15:0] corr_accel_z;
		logic signed [15:0] out_temperature;
		logic signed [15:0] corr_gyro_x;
		logic signed [15:0] corr_gyro_y;
		logic signed [15:0] corr_gyro_z;
		logic calib_active;
		logic calib_done;
	} out_item_t;

	typedef struct packed {
		logic start;
		logic [SUM_W-1:0] dividend;
		logic [DATA_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic [DATA_W-1:0] quotient;
	} div_rsp_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_START,
		S_WAIT,
		S_FINISH
	} ctrl_state_t;

endpackage

### src/imu_oc_div.sv
`timescale 1ns / 1ps
module imu_oc_div (
	input  logic clk,
	input  logic arst_n,
	input  imu_oc_pkg::div_req_t req,
	output imu_oc_pkg::div_rsp_t rsp
);
	import imu_oc_pkg::*;

	logic [DATA_W-1:0] rem_q;
	logic [SUM_W-1:0] quo_q;
	logic [DATA_W-1:0] dvs_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [DATA_W:0] trial;
	logic ge;

	// restoring division, one quotient bit per cycle
	assign trial = {rem_q, quo_q[SUM_W-1]};
	assign ge = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(SUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= ge ? DATA_W'(trial - {1'b0, dvs_q}) : trial[DATA_W-1:0];
			quo_q <= {quo_q[SUM_W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quotient = quo_q[DATA_W-1:0];

endmodule

### src/imu_offset_calibrator.sv
`timescale 1ns / 1ps
// Six-axis IMU offset calibrator. A measurement beat (cmd = 0) is corrected with the stored
// offsets and its result passes through res_q and then the output register. A calibration
// beat (cmd = 1) adds the raw axes to the running sums; the beat that reaches the configured
// sample count then runs six 32-bit divisions through one shared bit-serial divider, and
// in_ready stays low until that sweep has finished. cfg_data may be written only while the
// block is idle; a count of zero is treated as one. One result beat is produced per input
// beat.
module imu_offset_calibrator (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  imu_oc_pkg::in_item_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output imu_oc_pkg::out_item_t out_data,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [15:0] cfg_data
);
	import imu_oc_pkg::*;

	ctrl_state_t state_q, state_d;

	logic [DATA_W-1:0] count_q;
	logic [SUM_W-1:0] sums_q [NUM_AXES];
	logic signed [DATA_W-1:0] ofs_q [NUM_AXES];
	logic signed [DATA_W-1:0] mean_q [NUM_AXES];
	logic [DATA_W-1:0] samples_q;
	logic calibrating_q;
	logic [AXIS_IDX_W-1:0] idx_q;
	logic neg_q;

	out_item_t res_q;
	logic res_pend_q;
	out_item_t out_q;
	logic out_valid_q;

	logic in_fire;
	logic start_run;
	logic run_end;
	logic [DATA_W-1:0] d_eff;
	logic [DATA_W-1:0] samples_inc;
	logic signed [DATA_W-1:0] raw [NUM_AXES];
	logic signed [DATA_W-1:0] cur_ofs [NUM_AXES];
	logic signed [DATA_W-1:0] corr [NUM_AXES];
	logic div_start;
	logic fin;
	logic res_move;
	logic [SUM_W-1:0] sel_sum;
	logic [DATA_W:0] mag [3];
	logic [1:0] axis;
	logic signed [DATA_W-1:0] new_ofs [NUM_AXES];
	logic signed [DATA_W-1:0] tgt;

	div_req_t div_req;
	div_rsp_t div_rsp;

	imu_oc_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(div_req),
		.rsp(div_rsp)
	);

	assign cfg_ready = 1'b1;
	assign in_fire = in_valid && in_ready;

	assign raw[0] = in_data.raw_accel_x;
	assign raw[1] = in_data.raw_accel_y;
	assign raw[2] = in_data.raw_accel_z;
	assign raw[3] = in_data.raw_gyro_x;
	assign raw[4] = in_data.raw_gyro_y;
	assign raw[5] = in_data.raw_gyro_z;

	assign start_run = (in_data.cmd == CMD_CALIBRATE) && !calibrating_q;
	assign d_eff = (count_q == '0) ? DATA_W'(1) : count_q;
	assign samples_inc = (start_run ? '0 : samples_q) + 1'b1;
	assign run_end = (in_data.cmd == CMD_CALIBRATE) && (samples_inc >= d_eff);

	always_comb begin
		for (int i = 0; i < NUM_AXES; i++) begin
			cur_ofs[i] = start_run ? '0 : ofs_q[i];
			corr[i] = raw[i] + cur_ofs[i];
		end
	end

	// magnitude of the selected sum for the divider
	assign sel_sum = sums_q[idx_q];
	assign div_req.start = div_start;
	assign div_req.dividend = sel_sum[SUM_W-1] ? SUM_W'(0) - sel_sum : sel_sum;
	assign div_req.divisor = d_eff;

	// gravity axis pick and new offsets
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag[i] = mean_q[i][DATA_W-1] ? (DATA_W+1)'(0) - {1'b1, mean_q[i]}
				: {1'b0, mean_q[i]};
		end
		if (mag[0] >= mag[1] && mag[0] >= mag[2]) begin
			axis = 2'd0;
		end else if (mag[1] >= mag[2]) begin
			axis = 2'd1;
		end else begin
			axis = 2'd2;
		end
		for (int i = 0; i < 3; i++) begin
			tgt = '0;
			if (axis == 2'(i)) begin
				tgt = mean_q[i][DATA_W-1] ? ONE_G_NEG : ONE_G_POS;
			end
			new_ofs[i] = tgt - mean_q[i];
			new_ofs[3 + i] = -mean_q[3 + i];
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_fire && run_end) begin
					state_d = S_START;
				end
			end
			S_START: state_d = S_WAIT;
			S_WAIT: begin
				if (div_rsp.done) begin
					state_d = (idx_q == AXIS_IDX_W'(NUM_AXES - 1)) ? S_FINISH : S_START;
				end
			end
			S_FINISH: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		div_start = 1'b0;
		fin = 1'b0;
		case (state_q)
			S_IDLE: in_ready = !res_pend_q;
			S_START: div_start = 1'b1;
			S_FINISH: fin = 1'b1;
			default: ;
		endcase
	end

	assign res_move = res_pend_q && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= CALIB_COUNT_RST;
			samples_q <= '0;
			calibrating_q <= 1'b0;
			idx_q <= '0;
			res_pend_q <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < NUM_AXES; i++) begin
				sums_q[i] <= '0;
				ofs_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				count_q <= cfg_data;
			end
			if (res_move) begin
				res_pend_q <= 1'b0;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (in_fire) begin
				idx_q <= '0;
				if (start_run) begin
					for (int i = 0; i < NUM_AXES; i++) begin
						ofs_q[i] <= '0;
					end
				end
				if (in_data.cmd == CMD_CALIBRATE) begin
					for (int i = 0; i < NUM_AXES; i++) begin
						sums_q[i] <= (start_run ? '0 : sums_q[i])
							+ SUM_W'($signed(raw[i]));
					end
					calibrating_q <= 1'b1;
					samples_q <= run_end ? '0 : samples_inc;
				end
				if (!run_end) begin
					res_pend_q <= 1'b1;
				end
			end
			if (state_q == S_WAIT && div_rsp.done) begin
				idx_q <= idx_q + 1'b1;
			end
			if (fin) begin
				calibrating_q <= 1'b0;
				res_pend_q <= 1'b1;
				for (int i = 0; i < NUM_AXES; i++) begin
					ofs_q[i] <= new_ofs[i];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (div_start) begin
			neg_q <= sel_sum[SUM_W-1];
		end
		if (state_q == S_WAIT && div_rsp.done) begin
			mean_q[idx_q] <= neg_q ? DATA_W'(0) - div_rsp.quotient : div_rsp.quotient;
		end
		if (in_fire) begin
			res_q.corr_accel_x <= corr[0];
			res_q.corr_accel_y <= corr[1];
			res_q.corr_accel_z <= corr[2];
			res_q.out_temperature <= in_data.raw_temperature;
			res_q.corr_gyro_x <= corr[3];
			res_q.corr_gyro_y <= corr[4];
			res_q.corr_gyro_z <= corr[5];
			res_q.calib_active <= (in_data.cmd == CMD_CALIBRATE) ? !run_end : calibrating_q;
			res_q.calib_done <= 1'b0;
		end
		if (fin) begin
			res_q.calib_active <= 1'b0;
			res_q.calib_done <= 1'b1;
		end
		if (res_move) begin
			out_q <= res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

`ifndef ASSERT_OFF
	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !in_ready)
		else $error("input ready while a run is being finished");
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == S_WAIT))
		else $error("divider finished outside of the wait state");
	a_finish_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FINISH) |=> (res_pend_q && !calibrating_q))
		else $error("run end did not post a result");
	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.calib_done && out_data.calib_active))
		else $error("result both done and active");
	a_run_start_div: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && run_end) |=> (state_q == S_START && idx_q == '0))
		else $error("run end did not start the division sweep");
`endif

endmodule
